>>> src/hsv2rgb_pkg.sv
package hsv2rgb_pkg;

  localparam int HUE_W  = 16;
  localparam int CHAN_W = 8;
  localparam int SEC_W  = 3;
  localparam int H6_W   = HUE_W + SEC_W;

  // Q0.16 fraction times 255: full-scale term of q and t
  localparam logic [23:0] FULL_SCALED = 24'hFF0000;
  localparam logic [16:0] FRAC_ONE    = 17'h10000;
  localparam logic [7:0]  CHAN_MAX    = 8'd255;

  typedef enum logic [SEC_W-1:0] {
    SEC_RED_YEL  = 3'd0,
    SEC_YEL_GRN  = 3'd1,
    SEC_GRN_CYN  = 3'd2,
    SEC_CYN_BLU  = 3'd3,
    SEC_BLU_MAG  = 3'd4,
    SEC_MAG_RED  = 3'd5
  } sector_t;

endpackage

>>> src/hsv2rgb_if.sv
interface hsv2rgb_in_if;
  logic                           valid;
  logic                           ready;
  logic [hsv2rgb_pkg::HUE_W-1:0]  hue;
  logic [hsv2rgb_pkg::CHAN_W-1:0] saturation;
  logic [hsv2rgb_pkg::CHAN_W-1:0] brightness;

  modport source (output valid, output hue, output saturation, output brightness,
                  input ready);
  modport sink   (input valid, input hue, input saturation, input brightness,
                  output ready);
endinterface

interface hsv2rgb_out_if;
  logic                           valid;
  logic                           ready;
  logic [hsv2rgb_pkg::CHAN_W-1:0] red;
  logic [hsv2rgb_pkg::CHAN_W-1:0] green;
  logic [hsv2rgb_pkg::CHAN_W-1:0] blue;

  modport source (output valid, output red, output green, output blue, input ready);
  modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

>>> src/hsv_to_rgb_converter.sv
// HSV to RGB pixel converter, six-sector formula, exact truncating arithmetic.
// Five register stages; the first loads at the input accept edge, and out_pix.valid
// is the valid bit of the fifth.
// Throughput: one item per clock; each stage has its own valid bit and holds
// under output backpressure, so bubbles are squeezed out before in_pix.ready drops.
// Reset (rst_n low, synchronous): all stage valid bits clear; data registers keep.
module hsv_to_rgb_converter (
  input  logic                 clk,
  input  logic                 rst_n,
  hsv2rgb_in_if.sink           in_pix,
  hsv2rgb_out_if.source        out_pix
);

  // stage valids and enables
  logic vld1_r, vld2_r, vld3_r, vld4_r, vld5_r;
  logic en1, en2, en3, en4, en5;

  // stage 1: sector and fraction
  hsv2rgb_pkg::sector_t                  sec1_r;
  logic [hsv2rgb_pkg::HUE_W-1:0]         f1_r;
  logic [hsv2rgb_pkg::CHAN_W-1:0]        s1_r, v1_r;
  logic [hsv2rgb_pkg::H6_W-1:0]          h6;

  // stage 2: saturation terms
  hsv2rgb_pkg::sector_t                  sec2_r;
  logic [hsv2rgb_pkg::CHAN_W-1:0]        v2_r;
  logic [23:0]                           qterm2_r, tterm2_r;
  logic [15:0]                           pnum2_r;
  logic [23:0]                           fs;
  logic [24:0]                           gs;

  // stage 3: scaled by brightness, divided by 65536
  hsv2rgb_pkg::sector_t                  sec3_r;
  logic [hsv2rgb_pkg::CHAN_W-1:0]        v3_r;
  logic [15:0]                           py3_r, qy3_r, ty3_r;
  logic [31:0]                           qprod, tprod;

  // stage 4: quotient estimate for divide by 255
  hsv2rgb_pkg::sector_t                  sec4_r;
  logic [hsv2rgb_pkg::CHAN_W-1:0]        v4_r;
  logic [15:0]                           py4_r, qy4_r, ty4_r;
  logic [7:0]                            pe4_r, qe4_r, te4_r;

  // stage 5: corrected quotients, routed
  logic [7:0]                            pc, qc, tc;
  logic [hsv2rgb_pkg::CHAN_W-1:0]        red_nxt, green_nxt, blue_nxt;
  logic [hsv2rgb_pkg::CHAN_W-1:0]        red_r, green_r, blue_r;

  // floor(y/255) estimate, never above the true value and at most one below
  function automatic logic [7:0] div255_est(input logic [15:0] y);
    logic [15:0] sum;
    sum = y + {8'd0, y[15:8]};
    return sum[15:8];
  endfunction

  function automatic logic [7:0] div255_fix(input logic [15:0] y, input logic [7:0] est);
    logic [15:0] prod;
    logic [15:0] rem;
    prod = {est, 8'd0} - {8'd0, est};
    rem  = y - prod;
    return (rem >= 16'(hsv2rgb_pkg::CHAN_MAX)) ? est + 8'd1 : est;
  endfunction

  assign en5 = !vld5_r || out_pix.ready;
  assign en4 = !vld4_r || en5;
  assign en3 = !vld3_r || en4;
  assign en2 = !vld2_r || en3;
  assign en1 = !vld1_r || en2;
  assign in_pix.ready = en1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld1_r <= 1'b0;
      vld2_r <= 1'b0;
      vld3_r <= 1'b0;
      vld4_r <= 1'b0;
      vld5_r <= 1'b0;
    end else begin
      if (en1) vld1_r <= in_pix.valid;
      if (en2) vld2_r <= vld1_r;
      if (en3) vld3_r <= vld2_r;
      if (en4) vld4_r <= vld3_r;
      if (en5) vld5_r <= vld4_r;
    end
  end

  // hue * 6 as shift-add
  assign h6 = {1'b0, in_pix.hue, 2'b00} + {2'b00, in_pix.hue, 1'b0};

  always_ff @(posedge clk) begin
    if (en1) begin
      sec1_r <= hsv2rgb_pkg::sector_t'(h6[hsv2rgb_pkg::H6_W-1:hsv2rgb_pkg::HUE_W]);
      f1_r   <= h6[hsv2rgb_pkg::HUE_W-1:0];
      s1_r   <= in_pix.saturation;
      v1_r   <= in_pix.brightness;
    end
  end

  assign fs = 24'(f1_r) * 24'(s1_r);
  assign gs = 25'(hsv2rgb_pkg::FRAC_ONE - {1'b0, f1_r}) * 25'(s1_r);

  always_ff @(posedge clk) begin
    if (en2) begin
      sec2_r   <= sec1_r;
      v2_r     <= v1_r;
      qterm2_r <= hsv2rgb_pkg::FULL_SCALED - fs;
      // gs never exceeds 255*65536, so the difference stays in 24 bits
      tterm2_r <= 24'({1'b0, hsv2rgb_pkg::FULL_SCALED} - gs);
      pnum2_r  <= 16'(v1_r) * 16'(hsv2rgb_pkg::CHAN_MAX - s1_r);
    end
  end

  assign qprod = 32'(v2_r) * 32'(qterm2_r);
  assign tprod = 32'(v2_r) * 32'(tterm2_r);

  always_ff @(posedge clk) begin
    if (en3) begin
      sec3_r <= sec2_r;
      v3_r   <= v2_r;
      py3_r  <= pnum2_r;
      qy3_r  <= qprod[31:16];
      ty3_r  <= tprod[31:16];
    end
  end

  always_ff @(posedge clk) begin
    if (en4) begin
      sec4_r <= sec3_r;
      v4_r   <= v3_r;
      py4_r  <= py3_r;
      qy4_r  <= qy3_r;
      ty4_r  <= ty3_r;
      pe4_r  <= div255_est(py3_r);
      qe4_r  <= div255_est(qy3_r);
      te4_r  <= div255_est(ty3_r);
    end
  end

  assign pc = div255_fix(py4_r, pe4_r);
  assign qc = div255_fix(qy4_r, qe4_r);
  assign tc = div255_fix(ty4_r, te4_r);

  always_comb begin
    unique case (sec4_r)
      hsv2rgb_pkg::SEC_RED_YEL: begin
        red_nxt = v4_r; green_nxt = tc;   blue_nxt = pc;
      end
      hsv2rgb_pkg::SEC_YEL_GRN: begin
        red_nxt = qc;   green_nxt = v4_r; blue_nxt = pc;
      end
      hsv2rgb_pkg::SEC_GRN_CYN: begin
        red_nxt = pc;   green_nxt = v4_r; blue_nxt = tc;
      end
      hsv2rgb_pkg::SEC_CYN_BLU: begin
        red_nxt = pc;   green_nxt = qc;   blue_nxt = v4_r;
      end
      hsv2rgb_pkg::SEC_BLU_MAG: begin
        red_nxt = tc;   green_nxt = pc;   blue_nxt = v4_r;
      end
      default: begin
        red_nxt = v4_r; green_nxt = pc;   blue_nxt = qc;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en5) begin
      red_r   <= red_nxt;
      green_r <= green_nxt;
      blue_r  <= blue_nxt;
    end
  end

  assign out_pix.valid = vld5_r;
  assign out_pix.red   = red_r;
  assign out_pix.green = green_r;
  assign out_pix.blue  = blue_r;

`ifndef SYNTHESIS
  a_sector_range: assert property (@(posedge clk) disable iff (!rst_n)
    vld1_r |-> (sec1_r == hsv2rgb_pkg::SEC_RED_YEL || sec1_r == hsv2rgb_pkg::SEC_YEL_GRN ||
                sec1_r == hsv2rgb_pkg::SEC_GRN_CYN || sec1_r == hsv2rgb_pkg::SEC_CYN_BLU ||
                sec1_r == hsv2rgb_pkg::SEC_BLU_MAG || sec1_r == hsv2rgb_pkg::SEC_MAG_RED))
    else $error("hue sector out of range");

  a_div_one_step: assert property (@(posedge clk) disable iff (!rst_n)
    vld4_r |-> (qy4_r - ({qe4_r, 8'd0} - {8'd0, qe4_r})) < 16'd510)
    else $error("divide-by-255 estimate off by more than one");

  a_stall_only_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_pix.ready |-> (vld1_r && vld2_r && vld3_r && vld4_r && vld5_r && !out_pix.ready))
    else $error("input stalled with a bubble in the pipeline");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_pix.valid)
    else $error("result valid right after reset");
`endif

endmodule
